// File: rtl/bsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsf_pkg
// shared types and constants of the 3x3x3 binomial smoothing filter
// ----------------------------------------------------------------------------
package bsf_pkg;

  localparam int unsigned DEF_MAX_X = 128;
  localparam int unsigned DEF_MAX_Y = 128;
  localparam int unsigned DEF_MAX_Z = 128;

  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DENS_W    = 32;
  // weights sum to at most 64, so the weighted sum grows by six bits
  localparam int unsigned SUM_W     = DENS_W + 6;
  localparam int unsigned TOT_W     = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SIZE_Z = 2'd2;

  // cycles for the derived grid constants to follow a size write
  localparam logic [1:0] SETTLE_CYCLES = 2'd3;

  typedef struct packed {
    logic [DENS_W-1:0] density;
    logic              is_data;
  } bsf_in_t;

  typedef struct packed {
    logic [DENS_W-1:0] smoothed_density;
    logic              last_node;
  } bsf_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ACC,
    ST_DIVGO,
    ST_DIV,
    ST_OUT
  } bsf_state_e;

endpackage

// File: rtl/binomial_3d_smoothing_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binomial_3d_smoothing_filter_unit
// 3x3x3 binomial smoothing of a raster-ordered 3d density grid
// ----------------------------------------------------------------------------
// usage:
// - grid sizes are written on the cfg channel (valid/ready, always ready);
//   index 0/1/2 sets size x/y/z, a write to one of them restarts the grid
// - nodes enter on the in channel (valid/stall), x fastest, then y, then z;
//   is_data low marks a flush beat that pushes out the tail results
// - results leave on the out channel (valid/stall) in raster order, one plane
//   plus one row plus one node behind the input, last_node on the final one
// - an item that gives no result leaves the block idle; an item that gives a
//   result passes through the accept, 27 history reads through the single
//   read port of the history ram, one accumulate step, one divider start,
//   the bit-serial divider (38 quotient steps and the done flag), then the
//   output register load; the input stalls until that load
// - a finished result waits in the output register while the next item is
//   taken; a stalled receiver only holds the block once a second result is
//   ready to load
// - after reset and after each size write the block stalls its input while
//   the grid constants are recomputed; the history ram needs no clearing
//   since only nodes of the current grid are read
// ----------------------------------------------------------------------------
module binomial_3d_smoothing_filter_unit import bsf_pkg::*; #(
  parameter int unsigned MAX_X = DEF_MAX_X,
  parameter int unsigned MAX_Y = DEF_MAX_Y,
  parameter int unsigned MAX_Z = DEF_MAX_Z
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bsf_in_t              in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bsf_out_t             out_req_o
);

  localparam int unsigned XW    = $clog2(MAX_X + 1);
  localparam int unsigned YW    = $clog2(MAX_Y + 1);
  localparam int unsigned ZW    = $clog2(MAX_Z + 1);
  localparam int unsigned PW    = XW + YW;
  localparam int unsigned LIN_W = XW + YW + ZW;
  localparam int unsigned DEPTH = 2 * (MAX_X * MAX_Y + MAX_X + 1) + 1;
  localparam int unsigned AW    = $clog2(DEPTH);

  // modular add inside the history ring, both operands below DEPTH
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // ---------------------------------------------------------------- config
  logic             cfg_we, cfg_hit;
  logic [CFG_W-1:0] size_x_q, size_y_q, size_z_q;
  logic [1:0]       settle_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_hit     = cfg_we && (cfg_index_i == CFG_IDX_SIZE_X ||
                                  cfg_index_i == CFG_IDX_SIZE_Y ||
                                  cfg_index_i == CFG_IDX_SIZE_Z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= CFG_W'(64);
      size_y_q <= CFG_W'(64);
      size_z_q <= CFG_W'(64);
      settle_q <= SETTLE_CYCLES;
    end else begin
      if (cfg_we && cfg_index_i == CFG_IDX_SIZE_X) size_x_q <= cfg_data_i;
      if (cfg_we && cfg_index_i == CFG_IDX_SIZE_Y) size_y_q <= cfg_data_i;
      if (cfg_we && cfg_index_i == CFG_IDX_SIZE_Z) size_z_q <= cfg_data_i;
      if (cfg_hit) begin
        settle_q <= SETTLE_CYCLES;
      end else if (settle_q != 2'd0) begin
        settle_q <= settle_q - 2'd1;
      end
    end
  end

  // derived grid constants, three register stages
  logic [XW-1:0]    sx_q;
  logic [YW-1:0]    sy_q;
  logic [ZW-1:0]    sz_q;
  logic [PW-1:0]    plane_q;
  logic [LIN_W-1:0] n_q, lag_q;

  always_ff @(posedge clk_i) begin
    // zero means one, oversize clamps to the maximum
    sx_q <= (size_x_q == '0) ? XW'(1) : (32'(size_x_q) > MAX_X) ? XW'(MAX_X) : XW'(size_x_q);
    sy_q <= (size_y_q == '0) ? YW'(1) : (32'(size_y_q) > MAX_Y) ? YW'(MAX_Y) : YW'(size_y_q);
    sz_q <= (size_z_q == '0) ? ZW'(1) : (32'(size_z_q) > MAX_Z) ? ZW'(MAX_Z) : ZW'(size_z_q);
    plane_q <= PW'(sx_q) * PW'(sy_q);
    n_q     <= LIN_W'(plane_q) * LIN_W'(sz_q);
    lag_q   <= LIN_W'(plane_q) + LIN_W'(sx_q) + LIN_W'(1);
  end

  // ---------------------------------------------------------------- control
  bsf_state_e       state_q, state_d;
  logic             done_q, done_d, in_done_q, in_done_d;
  logic [LIN_W-1:0] in_lin_q, in_lin_d, out_lin_q, out_lin_d;
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, out_ptr_q, out_ptr_d;
  logic [XW-1:0]    out_x_q, out_x_d;
  logic [YW-1:0]    out_y_q, out_y_d;
  logic [ZW-1:0]    out_z_q, out_z_d;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       dx_q, dy_q, dz_q;
  logic             in_acc, restart_c, emit_go, mem_we, div_start, div_done;
  logic             out_load, last_q, read_end;
  logic             vx, vy, vz;
  logic [AW-1:0]    wr_ptr_e, base_addr;
  logic [LIN_W-1:0] in_lin_e;

  assign in_stall_o = !(state_q == ST_IDLE && settle_q == 2'd0);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign read_end   = dx_q == 2'd2 && dy_q == 2'd2 && dz_q == 2'd2;
  assign out_load   = state_q == ST_OUT && (!out_valid_q || !out_stall_i);

  // a data beat after the final result starts a new grid
  assign restart_c = in_req_i.is_data && done_q;
  assign wr_ptr_e  = restart_c ? '0 : wr_ptr_q;
  assign in_lin_e  = restart_c ? '0 : in_lin_q;
  assign base_addr = ring_add(out_ptr_q, AW'(DEPTH) - AW'(lag_q));

  always_comb begin
    state_d     = state_q;
    done_d      = done_q;
    in_done_d   = in_done_q;
    in_lin_d    = in_lin_q;
    wr_ptr_d    = wr_ptr_q;
    out_lin_d   = out_lin_q;
    out_ptr_d   = out_ptr_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_z_d     = out_z_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    emit_go     = 1'b0;
    div_start   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (restart_c) begin
            done_d    = 1'b0;
            out_lin_d = '0;
            out_ptr_d = '0;
            out_x_d   = '0;
            out_y_d   = '0;
            out_z_d   = '0;
          end
          if (in_req_i.is_data && !(in_done_q && !restart_c)) begin
            mem_we    = 1'b1;
            in_lin_d  = in_lin_e + LIN_W'(1);
            wr_ptr_d  = (wr_ptr_e == AW'(DEPTH - 1)) ? '0 : wr_ptr_e + AW'(1);
            in_done_d = (in_lin_e + LIN_W'(1)) >= n_q;
            emit_go   = in_lin_e >= lag_q;
          end else if (in_done_q && !done_q) begin
            // flush beat, or data beat once every node has arrived
            emit_go = 1'b1;
          end
          if (emit_go) state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (read_end) state_d = ST_ACC;
      end
      ST_ACC: begin
        state_d = ST_DIVGO;
      end
      ST_DIVGO: begin
        div_start = 1'b1;
        if (last_q) done_d = 1'b1;
        out_lin_d = out_lin_q + LIN_W'(1);
        out_ptr_d = (out_ptr_q == AW'(DEPTH - 1)) ? '0 : out_ptr_q + AW'(1);
        if ({1'b0, out_x_q} + (XW+1)'(1) >= {1'b0, sx_q}) begin
          out_x_d = '0;
          if ({1'b0, out_y_q} + (YW+1)'(1) >= {1'b0, sy_q}) begin
            out_y_d = '0;
            out_z_d = out_z_q + ZW'(1);
          end else begin
            out_y_d = out_y_q + YW'(1);
          end
        end else begin
          out_x_d = out_x_q + XW'(1);
        end
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      done_q      <= 1'b0;
      in_done_q   <= 1'b0;
      in_lin_q    <= '0;
      wr_ptr_q    <= '0;
      out_lin_q   <= '0;
      out_ptr_q   <= '0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_z_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (cfg_hit) begin
      // size write restarts the grid, history contents are kept
      state_q     <= ST_IDLE;
      done_q      <= 1'b0;
      in_done_q   <= 1'b0;
      in_lin_q    <= '0;
      wr_ptr_q    <= '0;
      out_lin_q   <= '0;
      out_ptr_q   <= '0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_z_q     <= '0;
      out_valid_q <= out_valid_d;
    end else begin
      state_q     <= state_d;
      done_q      <= done_d;
      in_done_q   <= in_done_d;
      in_lin_q    <= in_lin_d;
      wr_ptr_q    <= wr_ptr_d;
      out_lin_q   <= out_lin_d;
      out_ptr_q   <= out_ptr_d;
      out_x_q     <= out_x_d;
      out_y_q     <= out_y_d;
      out_z_q     <= out_z_d;
      out_valid_q <= out_valid_d;
    end
  end

  // ---------------------------------------------------------------- stencil
  logic [AW-1:0]     plane_addr_q, row_addr_q, addr_q;
  logic              rd_vld_q;
  logic [1:0]        rd_sh_q;
  logic [SUM_W-1:0]  acc_q;
  logic [TOT_W-1:0]  tot_q;
  logic [DENS_W-1:0] rdata, quotient;
  bsf_out_t          out_data_q;

  // neighbor inside the grid along each axis
  assign vx = (dx_q == 2'd0) ? (out_x_q != '0) :
              (dx_q == 2'd2) ? ({1'b0, out_x_q} + (XW+1)'(1) < {1'b0, sx_q}) : 1'b1;
  assign vy = (dy_q == 2'd0) ? (out_y_q != '0) :
              (dy_q == 2'd2) ? ({1'b0, out_y_q} + (YW+1)'(1) < {1'b0, sy_q}) : 1'b1;
  assign vz = (dz_q == 2'd0) ? (out_z_q != '0) :
              (dz_q == 2'd2) ? ({1'b0, out_z_q} + (ZW+1)'(1) < {1'b0, sz_q}) : 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dx_q     <= '0;
      dy_q     <= '0;
      dz_q     <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= state_q == ST_READ && vx && vy && vz;
      if (emit_go) begin
        dx_q <= '0;
        dy_q <= '0;
        dz_q <= '0;
      end else if (state_q == ST_READ) begin
        if (dx_q != 2'd2) begin
          dx_q <= dx_q + 2'd1;
        end else begin
          dx_q <= '0;
          if (dy_q != 2'd2) begin
            dy_q <= dy_q + 2'd1;
          end else begin
            dy_q <= '0;
            dz_q <= dz_q + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // center weight 2 per axis, i.e. one shift step per centered axis
    rd_sh_q <= 2'(dx_q == 2'd1) + 2'(dy_q == 2'd1) + 2'(dz_q == 2'd1);
    if (emit_go) begin
      plane_addr_q <= base_addr;
      row_addr_q   <= base_addr;
      addr_q       <= base_addr;
      acc_q        <= '0;
      tot_q        <= '0;
      last_q       <= out_lin_q + LIN_W'(1) == n_q;
    end else begin
      if (state_q == ST_READ) begin
        if (dx_q != 2'd2) begin
          addr_q <= ring_add(addr_q, AW'(1));
        end else if (dy_q != 2'd2) begin
          row_addr_q <= ring_add(row_addr_q, AW'(sx_q));
          addr_q     <= ring_add(row_addr_q, AW'(sx_q));
        end else begin
          plane_addr_q <= ring_add(plane_addr_q, AW'(plane_q));
          row_addr_q   <= ring_add(plane_addr_q, AW'(plane_q));
          addr_q       <= ring_add(plane_addr_q, AW'(plane_q));
        end
      end
      if (rd_vld_q) begin
        acc_q <= acc_q + (SUM_W'(rdata) << rd_sh_q);
        tot_q <= tot_q + (TOT_W'(1) << rd_sh_q);
      end
    end
    if (out_load) begin
      out_data_q.smoothed_density <= quotient;
      out_data_q.last_node        <= last_q;
    end
  end

  bsf_hist_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_ptr_e),
    .wdata_i (in_req_i.density),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  bsf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (tot_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_data_q;

endmodule

// File: rtl/bsf_hist_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsf_hist_mem
// node history ring, one write and one registered read port
// ----------------------------------------------------------------------------
module bsf_hist_mem import bsf_pkg::*; #(
  parameter int unsigned DEPTH = 33027,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DENS_W-1:0] wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DENS_W-1:0] rdata_o
);

  logic [DENS_W-1:0] mem_q [DEPTH];
  logic [DENS_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bsf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsf_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bsf_div import bsf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SUM_W-1:0]  dividend_i,
  input  logic [TOT_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [DENS_W-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(SUM_W);

  logic             busy_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [SUM_W-1:0] quo_q;
  logic [TOT_W-1:0] rem_q, div_q;
  logic [TOT_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CW'(SUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? TOT_W'(trial - {1'b0, div_q}) : trial[TOT_W-1:0];
      quo_q <= {quo_q[SUM_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[DENS_W-1:0];

endmodule

// File: tb/binomial_3d_smoothing_filter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binomial_3d_smoothing_filter_unit_tb
// self-checking bench for the 3x3x3 binomial smoothing filter
// ----------------------------------------------------------------------------
// streams small grids with random densities through the block, predicts every
// smoothed node with an in-bench grid model and checks results in order, with
// random gaps and receiver stalls, a long receiver hold-off and drained pauses
// ----------------------------------------------------------------------------
module binomial_3d_smoothing_filter_unit_tb;
  import bsf_pkg::*;

  localparam int unsigned HIST_DEPTH = 2 * (DEF_MAX_X * DEF_MAX_Y + DEF_MAX_X + 1) + 1;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned IDLE_WAIT = 100;   // longer than one result's latency
  localparam int unsigned RANDOM_ITEMS = 1750;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  bsf_in_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  bsf_out_t out_req_o;

  binomial_3d_smoothing_filter_unit dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // grid model state
  logic [CFG_W-1:0] size_reg [3];
  logic [DENS_W-1:0] node_ring [HIST_DEPTH];
  int unsigned in_count, out_count;
  int unsigned ox, oy, oz;
  bit all_in, grid_done;

  bsf_out_t pending_smooth [$];
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;
  bit no_gaps = 1'b0;          // burst stretch on the sender side
  bit no_stalls = 1'b0;        // burst stretch on the receiver side
  int unsigned hold_off = 0;   // one-shot long receiver hold-off

  function automatic int unsigned grid_dim(logic [CFG_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic void restart_grid();
    in_count = 0;
    out_count = 0;
    ox = 0;
    oy = 0;
    oz = 0;
    all_in = 1'b0;
    grid_done = 1'b0;
  endfunction

  // weighted 27-node average of the next output node
  function automatic void smooth_next(int unsigned sx, int unsigned sy, int unsigned sz);
    longint unsigned acc;
    int unsigned wsum, w, n;
    longint lin;
    bsf_out_t r;
    acc = 0;
    wsum = 0;
    for (int dz = -1; dz <= 1; dz++) begin
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          if (int'(oz) + dz < 0 || int'(oz) + dz >= int'(sz)) continue;
          if (int'(oy) + dy < 0 || int'(oy) + dy >= int'(sy)) continue;
          if (int'(ox) + dx < 0 || int'(ox) + dx >= int'(sx)) continue;
          w = (dx == 0 ? 2 : 1) * (dy == 0 ? 2 : 1) * (dz == 0 ? 2 : 1);
          lin = longint'(out_count) + dz * longint'(sx * sy) + dy * longint'(sx) + dx;
          acc += longint'(node_ring[lin % HIST_DEPTH]) * w;
          wsum += w;
        end
      end
    end
    n = sx * sy * sz;
    r.smoothed_density = (wsum != 0) ? DENS_W'(acc / wsum) : '0;
    r.last_node = (out_count + 1 == n);
    if (r.last_node) grid_done = 1'b1;
    pending_smooth.push_back(r);
    out_count++;
    if (++ox >= sx) begin
      ox = 0;
      if (++oy >= sy) begin
        oy = 0;
        oz++;
      end
    end
  endfunction

  function automatic void predict_node(bsf_in_t it);
    int unsigned sx, sy, sz, n, lag, wr;
    sx = grid_dim(size_reg[0], DEF_MAX_X);
    sy = grid_dim(size_reg[1], DEF_MAX_Y);
    sz = grid_dim(size_reg[2], DEF_MAX_Z);
    n = sx * sy * sz;
    lag = sx * sy + sx + 1;
    // data after completion opens a new grid
    if (it.is_data && grid_done) restart_grid();
    if (it.is_data && !all_in) begin
      wr = in_count;
      node_ring[wr % HIST_DEPTH] = it.density;
      in_count++;
      if (in_count >= n) all_in = 1'b1;
      if (wr >= lag) smooth_next(sx, sy, sz);
    end else if (all_in && !grid_done) begin
      smooth_next(sx, sy, sz);
    end
  endfunction

  task automatic send_node(logic [DENS_W-1:0] dens, logic is_data);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= '{density: dens, is_data: is_data};
    do @(posedge clk_i); while (in_stall_o);
    predict_node('{density: dens, is_data: is_data});
    items_sent++;
  endtask

  // no request in flight and nothing pending
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_smooth.size() != 0) @(posedge clk_i);
    repeat (IDLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_size(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    // only the three size registers exist; other indexes leave the grid alone
    if (idx == CFG_IDX_SIZE_X || idx == CFG_IDX_SIZE_Y || idx == CFG_IDX_SIZE_Z) begin
      size_reg[idx] = val;
      restart_grid();
    end
  endtask

  task automatic set_grid(logic [CFG_W-1:0] x, logic [CFG_W-1:0] y, logic [CFG_W-1:0] z);
    write_size(CFG_IDX_SIZE_X, x);
    write_size(CFG_IDX_SIZE_Y, y);
    write_size(CFG_IDX_SIZE_Z, z);
  endtask

  function automatic logic [DENS_W-1:0] pick_density();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  // full grid of random nodes, then flush and surplus data beats until the last node is out
  task automatic stream_grid();
    int unsigned n;
    n = grid_dim(size_reg[0], DEF_MAX_X) * grid_dim(size_reg[1], DEF_MAX_Y)
        * grid_dim(size_reg[2], DEF_MAX_Z);
    for (int unsigned i = 0; i < n; i++) send_node(pick_density(), 1'b1);
    while (!grid_done) send_node(pick_density(), $urandom_range(0, 3) == 0);
  endtask

  task automatic test_reset_sizes();
    // default 64^3 grid: a few nodes, far below the lag, no results
    for (int i = 0; i < 5; i++) send_node(pick_density(), 1'b1);
  endtask

  task automatic test_directed();
    set_grid(8'd2, 8'd2, 8'd2);
    send_node('1, 1'b0);                 // early flush does nothing
    send_node('0, 1'b1);
    send_node('1, 1'b1);
    for (int i = 0; i < 6; i++) send_node(i[0] ? '1 : 32'h8000_0001, 1'b1);
    send_node(32'h1234_5678, 1'b1);      // data after last input acts as a flush
    while (!grid_done) send_node('0, 1'b0);
    send_node('1, 1'b0);                 // flush after completion gives nothing
    send_node(32'hdead_beef, 1'b1);      // data after completion starts a new grid
    stream_grid();
    set_grid(8'd0, 8'd0, 8'd0);          // zero sizes behave as one
    send_node('1, 1'b1);
    send_node('0, 1'b0);
    write_size(2'd3, 8'h55);             // unused index
    send_node(32'h0001_0000, 1'b1);
    send_node('0, 1'b0);
  endtask

  task automatic test_extreme_sizes();
    set_grid(8'd128, 8'd1, 8'd1);
    stream_grid();
    set_grid(8'd1, 8'd255, 8'd1);
    stream_grid();
    set_grid(8'd1, 8'd1, 8'd200);
    stream_grid();
    set_grid(8'd3, 8'd129, 8'd1);
    stream_grid();
  endtask

  task automatic test_backpressure();
    set_grid(8'd3, 8'd2, 8'd2);
    hold_off = 2000;
    no_gaps = 1'b1;
    stream_grid();
    no_gaps = 1'b0;
    wait_drained();
    stream_grid();
  endtask

  task automatic test_random_grids();
    while (items_sent < RANDOM_ITEMS) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      no_stalls = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 6) == 0) begin
        // wide random register values with the other sizes kept tiny
        set_grid($urandom_range(0, 255), 8'd1, 8'd1);
      end else begin
        set_grid($urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(0, 4));
      end
      if ($urandom_range(0, 5) == 0) begin
        // broken grid: a few nodes and noise, then the sizes change
        for (int i = $urandom_range(1, 8); i > 0; i--)
          send_node(pick_density(), $urandom_range(0, 3) != 0);
        continue;
      end
      for (int g = $urandom_range(1, 3); g > 0; g--) stream_grid();
      if ($urandom_range(0, 3) == 0) send_node(pick_density(), 1'b0);
    end
    no_gaps = 1'b0;
    no_stalls = 1'b0;
  endtask

  // receiver stall pattern
  initial begin
    int unsigned n;
    forever begin
      if (hold_off != 0) begin
        n = hold_off;
        hold_off = 0;
      end else begin
        n = no_stalls ? 0 : $urandom_range(0, 17);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    bsf_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_smooth.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h/%b", $time,
                 out_req_o.smoothed_density, out_req_o.last_node);
        errors++;
      end else begin
        want = pending_smooth.pop_front();
        if (out_req_o.smoothed_density !== want.smoothed_density) begin
          $display("%0t: smoothed_density expected %h actual %h", $time,
                   want.smoothed_density, out_req_o.smoothed_density);
          errors++;
        end
        if (out_req_o.last_node !== want.last_node) begin
          $display("%0t: last_node expected %b actual %b", $time,
                   want.last_node, out_req_o.last_node);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    size_reg[0] = 8'd64;
    size_reg[1] = 8'd64;
    size_reg[2] = 8'd64;
    restart_grid();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_sizes();
    test_directed();
    test_extreme_sizes();
    test_backpressure();
    test_random_grids();
    wait_drained();
    if (errors == 0 && pending_smooth.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
